/* hw/rtl/imh_pkg.sv */
`timescale 1ns / 1ps
package imh_pkg;
   localparam int HeapCapacity = 1024;
   localparam int ZoneCount = 1024;
   localparam int KeyBits = 32;
   localparam int SlotBits = $clog2(HeapCapacity + 1);
   localparam int CountBits = 11;
   localparam int ZoneBits = 10;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_UPDATE = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;
   localparam logic [1:0] ST_ABSENT = 2'd3;

   // one slot write request
   typedef struct packed {
      logic en;
      logic [SlotBits-1:0] addr;
      logic [ZoneBits-1:0] zone;
      logic [KeyBits-1:0] key;
   } slot_wr_type;
endpackage

/* hw/rtl/imh_slot_ram.sv */
`timescale 1ns / 1ps
module imh_slot_ram import imh_pkg::*; (
   input  logic clock,
   input  slot_wr_type wr,
   input  logic [SlotBits-1:0] rd_addr_a,
   input  logic [SlotBits-1:0] rd_addr_b,
   output logic [ZoneBits-1:0] rd_zone_a,
   output logic [KeyBits-1:0] rd_key_a,
   output logic [ZoneBits-1:0] rd_zone_b,
   output logic [KeyBits-1:0] rd_key_b
);
   localparam int Depth = HeapCapacity + 1;
   logic [ZoneBits+KeyBits-1:0] mem [Depth];

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr.en) mem[wr.addr] <= {wr.zone, wr.key};
      {rd_zone_a, rd_key_a} <= mem[rd_addr_a];
      {rd_zone_b, rd_key_b} <= mem[rd_addr_b];
   end
endmodule

/* hw/rtl/imh_pos_ram.sv */
`timescale 1ns / 1ps
module imh_pos_ram import imh_pkg::*; (
   input  logic clock,
   input  logic wr_en,
   input  logic [ZoneBits-1:0] wr_addr,
   input  logic [SlotBits-1:0] wr_data,
   input  logic [ZoneBits-1:0] rd_addr,
   output logic [SlotBits-1:0] rd_data
);
   logic [SlotBits-1:0] mem [ZoneCount];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

/* hw/rtl/indexed_max_heap_gc_victim.sv */
`timescale 1ns / 1ps
// a transaction reads its position, decides the operation, sifts if needed, then
// reads the root and registers the result
// one transaction at a time; a held result stalls the next one before its root read
// reset: sync active high; a clearing pass zeroes every entry of the position
// table before the first transaction is accepted
module indexed_max_heap_gc_victim import imh_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_op,
   input  logic [9:0] req_zone_id,
   input  logic [31:0] req_new_key,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_status,
   output logic [9:0] rsp_top_zone,
   output logic [31:0] rsp_top_key,
   output logic [10:0] rsp_heap_count,
   output logic rsp_heap_empty
);
   typedef enum logic [11:0] {
      S_CLEAR  = 12'b000000000001,
      S_IDLE   = 12'b000000000010,
      S_POS    = 12'b000000000100,
      S_DEC    = 12'b000000001000,
      S_LAST   = 12'b000000010000,
      S_RESIFT = 12'b000000100000,
      S_UPRD   = 12'b000001000000,
      S_UPCMP  = 12'b000010000000,
      S_DNRD   = 12'b000100000000,
      S_DNCMP  = 12'b001000000000,
      S_ROOT   = 12'b010000000000,
      S_RSP    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic [SlotBits-1:0] count_ff, count_in;
   logic [SlotBits-1:0] pos_ff, pos_in;
   logic [ZoneBits-1:0] clr_ff, clr_in;
   logic [1:0] op_ff, op_in;
   logic [ZoneBits-1:0] zone_ff, zone_in;
   logic [KeyBits-1:0] key_ff, key_in;
   logic [ZoneBits-1:0] ez_ff, ez_in;
   logic [1:0] status_ff, status_in;
   logic [ZoneBits-1:0] tz_ff, tz_in;
   logic [KeyBits-1:0] tk_ff, tk_in;

   slot_wr_type wr;
   logic [SlotBits-1:0] ra, rb;
   logic [ZoneBits-1:0] za, zb;
   logic [KeyBits-1:0] ka, kb;
   logic pw_en;
   logic [ZoneBits-1:0] pw_addr, pr_addr;
   logic [SlotBits-1:0] pw_data, pr_data;

   imh_slot_ram u_slot (.clock, .wr, .rd_addr_a(ra), .rd_addr_b(rb),
      .rd_zone_a(za), .rd_key_a(ka), .rd_zone_b(zb), .rd_key_b(kb));
   imh_pos_ram u_pos (.clock, .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(pr_addr), .rd_data(pr_data));

   logic held;
   logic [SlotBits-1:0] lchild, rchild, parent;
   logic take_r;
   assign held = (pr_data != '0) && (pr_data <= count_ff);
   assign lchild = {pos_ff[SlotBits-2:0], 1'b0};
   assign rchild = {pos_ff[SlotBits-2:0], 1'b1};
   assign parent = {1'b0, pos_ff[SlotBits-1:1]};
   assign take_r = (lchild != count_ff) && (kb > ka);

   // control sequencer: read, compare, write back one level at a time
   always_comb begin
      state_in = state_ff; count_in = count_ff; pos_in = pos_ff; clr_in = clr_ff;
      op_in = op_ff; zone_in = zone_ff; key_in = key_ff; ez_in = ez_ff;
      status_in = status_ff; tz_in = tz_ff; tk_in = tk_ff;
      wr = '0; ra = pos_ff; rb = pos_ff;
      pw_en = 1'b0; pw_addr = zone_ff; pw_data = pos_ff; pr_addr = zone_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            pw_en = 1'b1; pw_addr = clr_ff; pw_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ZoneBits'(ZoneCount - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            pr_addr = req_zone_id;
            if (req_valid) begin
               op_in = req_op; zone_in = req_zone_id; key_in = req_new_key;
               status_in = ST_OK; state_in = S_POS;
            end
         end
         S_POS: begin
            // position read is back; decide the operation
            state_in = S_ROOT;
            pos_in = pr_data;
            case (op_ff)
               OP_INSERT: begin
                  if (held) status_in = ST_PRESENT;
                  else if (count_ff == SlotBits'(HeapCapacity)) status_in = ST_FULL;
                  else begin
                     count_in = count_ff + 1'b1;
                     pos_in = count_ff + 1'b1;
                     ez_in = zone_ff;
                     state_in = S_UPRD;
                  end
               end
               OP_UPDATE: begin
                  if (!held) status_in = ST_ABSENT;
                  else begin
                     ez_in = zone_ff; state_in = S_RESIFT;
                  end
               end
               OP_DELETE: begin
                  if (!held) status_in = ST_ABSENT;
                  else begin
                     pw_en = 1'b1; pw_data = '0;
                     count_in = count_ff - 1'b1;
                     if (pr_data == count_ff) state_in = S_ROOT;
                     else begin
                        ra = count_ff; state_in = S_LAST;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_LAST: begin
            // last entry read; it becomes the moving entry
            ez_in = za; key_in = ka; state_in = S_RESIFT;
         end
         S_RESIFT: begin
            ra = parent; state_in = S_DEC;
         end
         S_DEC: begin
            if (pos_ff == SlotBits'(1) || ka > key_ff) begin
               ra = lchild; rb = rchild; state_in = S_DNCMP;
               if (lchild > count_ff || pos_ff[SlotBits-1]) begin
                  wr = '{1'b1, pos_ff, ez_ff, key_ff};
                  pw_en = 1'b1; pw_addr = ez_ff; state_in = S_ROOT;
               end
            end else begin
               // keep the parent on the read port for the climb
               ra = parent; state_in = S_UPCMP;
            end
         end
         S_UPRD: begin
            ra = parent; state_in = S_UPCMP;
         end
         S_UPCMP: begin
            if (pos_ff != SlotBits'(1) && key_ff > ka) begin
               wr = '{1'b1, pos_ff, za, ka};
               pw_en = 1'b1; pw_addr = za;
               pos_in = parent; state_in = S_UPRD;
            end else begin
               wr = '{1'b1, pos_ff, ez_ff, key_ff};
               pw_en = 1'b1; pw_addr = ez_ff; state_in = S_ROOT;
            end
         end
         S_DNRD: begin
            ra = lchild; rb = rchild;
            if (lchild > count_ff || pos_ff[SlotBits-1]) begin
               wr = '{1'b1, pos_ff, ez_ff, key_ff};
               pw_en = 1'b1; pw_addr = ez_ff; state_in = S_ROOT;
            end else state_in = S_DNCMP;
         end
         S_DNCMP: begin
            if (key_ff < (take_r ? kb : ka)) begin
               wr = '{1'b1, pos_ff, take_r ? zb : za, take_r ? kb : ka};
               pw_en = 1'b1; pw_addr = take_r ? zb : za;
               pos_in = take_r ? rchild : lchild; state_in = S_DNRD;
            end else begin
               wr = '{1'b1, pos_ff, ez_ff, key_ff};
               pw_en = 1'b1; pw_addr = ez_ff; state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            ra = SlotBits'(1); state_in = S_RSP;
         end
         S_RSP: begin
            if (count_ff == '0) begin
               tz_in = '0; tk_in = '0;
            end else begin
               tz_in = za; tk_in = ka;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: a held response blocks the next read of the root
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rs_ff;
   logic [SlotBits-1:0] rc_ff;
   logic rsp_wait;
   assign rsp_wait = rsp_valid_ff && !rsp_ready;
   assign rsp_valid_in = (state_ff == S_RSP) ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; count_ff <= '0; clr_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (!(state_ff == S_ROOT && rsp_wait)) state_ff <= state_in;
         count_ff <= count_in; clr_ff <= clr_in; rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in; op_ff <= op_in; zone_ff <= zone_in; key_ff <= key_in;
      ez_ff <= ez_in; status_ff <= status_in; tz_ff <= tz_in; tk_ff <= tk_in;
      if (state_ff == S_RSP) begin
         rs_ff <= status_ff; rc_ff <= count_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rs_ff;
   assign rsp_top_zone = tz_ff;
   assign rsp_top_key = tk_ff;
   assign rsp_heap_count = CountBits'(rc_ff);
   assign rsp_heap_empty = (rc_ff == '0);
endmodule

/* bench/tb_indexed_max_heap_gc_victim.sv */
`timescale 1ns / 1ps
module tb_indexed_max_heap_gc_victim import imh_pkg::*; ();

   localparam int RandomOps = 340;
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = OP_INSERT;
   logic [9:0] req_zone_id = '0;
   logic [31:0] req_new_key = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [9:0] rsp_top_zone;
   logic [31:0] rsp_top_key;
   logic [10:0] rsp_heap_count;
   logic rsp_heap_empty;

   indexed_max_heap_gc_victim dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [1:0] status;
      logic [9:0] top_zone;
      logic [31:0] top_key;
      logic [10:0] heap_count;
      logic heap_empty;
   } heap_view_type;

   typedef struct packed {
      logic [1:0] op;
      logic [9:0] zone;
      logic [31:0] key;
      logic fixed;
      heap_view_type view;
   } stim_row_type;

   // shadow heap
   logic [9:0] shadow_zone [1:HeapCapacity];
   logic [31:0] shadow_key [1:HeapCapacity];
   int shadow_pos [ZoneCount];
   int shadow_count;

   heap_view_type pending_views [$];
   int errors = 0;

   function automatic void put_slot(int p, logic [9:0] z, logic [31:0] k);
      shadow_zone[p] = z;
      shadow_key[p] = k;
      shadow_pos[z] = p;
   endfunction

   function automatic void bubble_up(int p);
      logic [9:0] z;
      logic [31:0] k;
      z = shadow_zone[p];
      k = shadow_key[p];
      while (p > 1 && k > shadow_key[p/2]) begin
         put_slot(p, shadow_zone[p/2], shadow_key[p/2]);
         p = p / 2;
      end
      put_slot(p, z, k);
   endfunction

   function automatic void bubble_down(int p);
      logic [9:0] z;
      logic [31:0] k;
      int c;
      z = shadow_zone[p];
      k = shadow_key[p];
      while (p * 2 <= shadow_count) begin
         c = p * 2;
         if (c != shadow_count && shadow_key[c+1] > shadow_key[c]) c++;
         if (k < shadow_key[c]) begin
            put_slot(p, shadow_zone[c], shadow_key[c]);
            p = c;
         end else break;
      end
      put_slot(p, z, k);
   endfunction

   function automatic void rebalance(int p);
      if (p == 1 || shadow_key[p/2] > shadow_key[p]) bubble_down(p);
      else bubble_up(p);
   endfunction

   function automatic heap_view_type apply_heap_op(logic [1:0] op, logic [9:0] zone,
                                                   logic [31:0] key);
      heap_view_type v;
      int p;
      bit held;
      int last;
      p = shadow_pos[zone];
      held = (p >= 1 && p <= shadow_count);
      v = '0;
      v.status = ST_OK;
      case (op)
         OP_INSERT: begin
            if (held) v.status = ST_PRESENT;
            else if (shadow_count >= HeapCapacity) v.status = ST_FULL;
            else begin
               shadow_count++;
               put_slot(shadow_count, zone, key);
               bubble_up(shadow_count);
            end
         end
         OP_UPDATE: begin
            if (!held) v.status = ST_ABSENT;
            else begin
               shadow_key[p] = key;
               rebalance(p);
            end
         end
         OP_DELETE: begin
            if (!held) v.status = ST_ABSENT;
            else begin
               shadow_pos[zone] = 0;
               if (p == shadow_count) shadow_count--;
               else begin
                  last = shadow_count;
                  shadow_count--;
                  put_slot(p, shadow_zone[last], shadow_key[last]);
                  rebalance(p);
               end
            end
         end
         default: ;
      endcase
      v.heap_count = shadow_count[10:0];
      if (shadow_count == 0) v.heap_empty = 1'b1;
      else begin
         v.top_zone = shadow_zone[1];
         v.top_key = shadow_key[1];
      end
      return v;
   endfunction

   // directed table; fixed rows carry hand-read expectations
   function automatic stim_row_type row(logic [1:0] op, logic [9:0] z, logic [31:0] k,
                                        logic fx = 1'b0, logic [1:0] st = ST_OK,
                                        logic [9:0] tz = '0, logic [31:0] tk = '0,
                                        logic [10:0] cnt = '0, logic em = 1'b0);
      stim_row_type r;
      r.op = op; r.zone = z; r.key = k; r.fixed = fx;
      r.view = '{status: st, top_zone: tz, top_key: tk, heap_count: cnt, heap_empty: em};
      return r;
   endfunction

   stim_row_type directed [$];

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   // drive one transaction and drop valid at the falling edge after acceptance
   task automatic send(logic [1:0] op, logic [9:0] z, logic [31:0] k);
      req_op <= op;
      req_zone_id <= z;
      req_new_key <= k;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // record expectation at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending_views.push_back(apply_heap_op(req_op, req_zone_id, req_new_key));
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      heap_view_type want, got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_top_zone, rsp_top_key, rsp_heap_count, rsp_heap_empty};
         if (pending_views.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result transaction %p", got);
         end else begin
            want = pending_views.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // receiver stalls
   initial begin
      @(negedge clock);
      while (1) begin
         if ($urandom_range(0, 19) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(5, 40)) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      stim_row_type r;
      heap_view_type fixed_view;
      int held_zones [$];
      int idx;
      int sel;
      logic [9:0] z;
      logic [31:0] k;

      for (int i = 0; i < ZoneCount; i++) shadow_pos[i] = 0;
      shadow_count = 0;

      // directed: empty-heap flags, extremes, ties, every op
      directed.push_back(row(OP_DELETE, 10'd5, 32'd0, 1'b1, ST_ABSENT, 10'd0, 32'd0,
                             11'd0, 1'b1));
      directed.push_back(row(OP_UPDATE, 10'd5, 32'd9, 1'b1, ST_ABSENT, 10'd0, 32'd0,
                             11'd0, 1'b1));
      directed.push_back(row(OP_SPARE, 10'd5, 32'd9, 1'b1, ST_OK, 10'd0, 32'd0,
                             11'd0, 1'b1));
      directed.push_back(row(OP_INSERT, 10'd0, 32'd0, 1'b1, ST_OK, 10'd0, 32'd0,
                             11'd1, 1'b0));
      directed.push_back(row(OP_INSERT, 10'd1023, 32'hFFFF_FFFF, 1'b1, ST_OK, 10'd1023,
                             32'hFFFF_FFFF, 11'd2, 1'b0));
      directed.push_back(row(OP_INSERT, 10'd0, 32'd7, 1'b1, ST_PRESENT, 10'd1023,
                             32'hFFFF_FFFF, 11'd2, 1'b0));
      directed.push_back(row(OP_INSERT, 10'h2AA, 32'hFFFF_FFFF, 1'b1, ST_OK, 10'd1023,
                             32'hFFFF_FFFF, 11'd3, 1'b0));
      directed.push_back(row(OP_INSERT, 10'h155, 32'h5555_5555));
      directed.push_back(row(OP_INSERT, 10'd7, 32'hAAAA_AAAA));
      directed.push_back(row(OP_INSERT, 10'd8, 32'h5555_5555));
      directed.push_back(row(OP_UPDATE, 10'd0, 32'h8000_0000));
      directed.push_back(row(OP_UPDATE, 10'd1023, 32'd0));
      directed.push_back(row(OP_UPDATE, 10'h155, 32'h5555_5555));
      directed.push_back(row(OP_SPARE, 10'd3, 32'd3));
      directed.push_back(row(OP_DELETE, 10'h2AA, 32'hFFFF_FFFF));
      directed.push_back(row(OP_DELETE, 10'd8, 32'd0));
      directed.push_back(row(OP_DELETE, 10'd8, 32'd0));
      directed.push_back(row(OP_DELETE, 10'd7, 32'd0));
      directed.push_back(row(OP_DELETE, 10'd0, 32'd0));
      directed.push_back(row(OP_DELETE, 10'h155, 32'd0));
      directed.push_back(row(OP_DELETE, 10'd1023, 32'd0, 1'b1, ST_OK, 10'd0, 32'd0,
                             11'd0, 1'b1));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         r = directed[i];
         fixed_view = r.view;
         send(r.op, r.zone, r.key);
         // hand-read rows cross-check the shadow heap too
         if (r.fixed && pending_views.size() > 0 &&
             pending_views[pending_views.size()-1] !== fixed_view) begin
            errors++;
            if (errors <= 10)
               $display("table row %0d: expected %p got %p", i, fixed_view,
                        pending_views[pending_views.size()-1]);
         end
         idle_gap();
      end

      // fill to capacity, then keep churning
      for (int i = 0; i < HeapCapacity; i++) begin
         send(OP_INSERT, i[9:0], $urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                            : $urandom());
         if ($urandom_range(0, 15) == 0) idle_gap();
      end
      send(OP_INSERT, 10'd3, 32'd1);
      send(OP_UPDATE, 10'd3, 32'hFFFF_FFFF);

      // sender holds off until every result is back
      while (pending_views.size() != 0) @(negedge clock);

      for (int i = 0; i < 64; i++)
         send(OP_DELETE, 10'($urandom_range(0, 1023)), 32'd0);

      for (int i = 0; i < RandomOps; i++) begin
         held_zones.delete();
         for (int zz = 0; zz < ZoneCount; zz++)
            if (shadow_pos[zz] != 0) held_zones.push_back(zz);
         sel = $urandom_range(0, 19);
         if (held_zones.size() > 0 && sel < 16) begin
            idx = $urandom_range(0, held_zones.size() - 1);
            z = 10'(held_zones[idx]);
         end else z = 10'($urandom_range(0, 1023));
         // narrow keys often to force ties
         k = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 7) : $urandom();
         if (sel == 19) send(OP_SPARE, z, k);
         else if (sel < 7) send(OP_DELETE, z, k);
         else if (sel < 13) send(OP_UPDATE, z, k);
         else send(OP_INSERT, z, k);
         idle_gap();
      end

      while (pending_views.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
